// ===== design/kwt_pkg.sv =====
// ----------------------------------------------------------------------------
// kwt_pkg: shared definitions for the keyword tokenizer
// Token codes, character codes, keyword spellings and the word buffer type.
// ----------------------------------------------------------------------------
package kwt_pkg;

    // Sizing of the word buffer and keyword set
    localparam int unsigned MAX_KEYWORD_LEN = 10;
    localparam int unsigned NUM_KEYWORDS    = 28;
    localparam int unsigned KW_TABLE_SIZE   = 28;
    localparam int unsigned KW_SLOT         = 12;

    localparam int unsigned LEN_W   = $clog2(MAX_KEYWORD_LEN + 1);
    localparam int unsigned IDX_W   = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;
    localparam int unsigned TOKEN_W = 6;
    localparam int unsigned CHAR_W  = 8;

    typedef logic [TOKEN_W-1:0]                     token_t;
    typedef logic [LEN_W-1:0]                       word_len_t;
    typedef logic [MAX_KEYWORD_LEN-1:0][CHAR_W-1:0] word_buf_t;

    // Token codes
    localparam token_t TK_END       = 6'd0;
    localparam token_t TK_SEMI      = 6'd1;
    localparam token_t TK_OPEN_PAR  = 6'd2;
    localparam token_t TK_CLOSE_PAR = 6'd3;
    localparam token_t TK_OPEN_BR   = 6'd4;
    localparam token_t TK_CLOSE_BR  = 6'd5;
    localparam token_t TK_COMMA     = 6'd6;
    localparam token_t TK_ASSIGN    = 6'd7;
    localparam token_t TK_COLON     = 6'd8;
    localparam token_t TK_RANGE     = 6'd9;
    localparam token_t TK_PERIOD    = 6'd10;
    localparam token_t TK_SUB       = 6'd11;
    localparam token_t TK_ADD       = 6'd12;
    localparam token_t TK_MUL       = 6'd13;
    localparam token_t TK_DIV       = 6'd14;
    localparam token_t TK_MOD       = 6'd15;
    localparam token_t TK_EQ        = 6'd16;
    localparam token_t TK_LE        = 6'd17;
    localparam token_t TK_NE        = 6'd18;
    localparam token_t TK_LT        = 6'd19;
    localparam token_t TK_GE        = 6'd20;
    localparam token_t TK_GT        = 6'd21;
    localparam token_t TK_NUM       = 6'd22;
    localparam token_t TK_IDENT     = 6'd23;
    localparam token_t TK_ERR       = 6'd24;
    localparam token_t TK_KW_BASE   = 6'd25;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_COLON   = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_EQUAL   = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_LESS    = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GREATER = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_UNDER   = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_SEMI    = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_LPAR    = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAR    = 8'h29;
    localparam logic [CHAR_W-1:0] CH_LBR     = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBR     = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z    = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    // Keyword spellings, right-justified: the first letter sits in the
    // highest used byte, the last letter in bits [7:0]
    localparam logic [KW_SLOT*CHAR_W-1:0] KW_TEXT [KW_TABLE_SIZE] = '{
        96'("procedure"), 96'("is"),      96'("begin"),   96'("end"),
        96'("function"),  96'("return"),  96'("in"),      96'("out"),
        96'("package"),   96'("private"), 96'("type"),    96'("integer"),
        96'("boolean"),   96'("array"),   96'("of"),      96'("record"),
        96'("null"),      96'("if"),      96'("then"),    96'("elsif"),
        96'("else"),      96'("while"),   96'("loop"),    96'("true"),
        96'("false"),     96'("not"),     96'("and"),     96'("or")
    };

    localparam int unsigned KW_LEN [KW_TABLE_SIZE] = '{
        9, 2, 5, 3, 8, 6, 2, 3, 7, 7, 4, 7, 7, 5,
        2, 6, 4, 2, 4, 5, 4, 5, 4, 4, 5, 3, 3, 2
    };

    localparam int unsigned KW_LIMIT =
        (NUM_KEYWORDS > KW_TABLE_SIZE) ? KW_TABLE_SIZE : NUM_KEYWORDS;

endpackage

// ===== design/kwt_classify.sv =====
// ----------------------------------------------------------------------------
// kwt_classify: keyword lookup for a finished word
// Compares the lower-cased word buffer against every keyword in parallel and
// returns the keyword token, or IDENTIFIER when nothing matches or the word was too long.
// ----------------------------------------------------------------------------
module kwt_classify (
    input  kwt_pkg::word_buf_t word_buf,
    input  kwt_pkg::word_len_t word_len,
    input  logic               word_too_long,
    output kwt_pkg::token_t    word_kind
);

    logic [kwt_pkg::KW_LIMIT-1:0] hit;

    // Match length and each used letter of every keyword
    always_comb begin
        for (int i = 0; i < kwt_pkg::KW_LIMIT; i++) begin
            hit[i] = (int'(word_len) == kwt_pkg::KW_LEN[i]) &&
                     (kwt_pkg::KW_LEN[i] <= kwt_pkg::MAX_KEYWORD_LEN);
            for (int j = 0; j < kwt_pkg::MAX_KEYWORD_LEN; j++) begin
                if (j < kwt_pkg::KW_LEN[i] && j < kwt_pkg::KW_SLOT) begin
                    if (word_buf[j] !=
                        kwt_pkg::KW_TEXT[i][8*(kwt_pkg::KW_LEN[i]-1-j) +: 8]) begin
                        hit[i] = 1'b0;
                    end
                end
            end
        end
    end

    // Pick the first matching keyword in table order
    always_comb begin
        word_kind = kwt_pkg::TK_IDENT;
        if (!word_too_long) begin
            for (int i = kwt_pkg::KW_LIMIT - 1; i >= 0; i--) begin
                if (hit[i]) begin
                    word_kind = kwt_pkg::token_t'(kwt_pkg::TK_KW_BASE + i);
                end
            end
        end
    end

endmodule

// ===== design/keyword_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// keyword_tokenizer_unit: streaming lexical tokenizer
// Takes one source byte per beat and emits token codes, skipping white space
// and block comments, pairing two-character operators and matching keywords.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Beat contents
//  ---------+-----+-------------------------------------------------------
//  s_       | in  | tdata[7:0] char_code; tuser end_of_input
//  m_       | out | tdata[5:0] token_kind; tlast last_of_run
//
//  One byte is taken per cycle while s_tready is high; its tokens are registered into the result queue.
//  Tokens go into a three-entry result queue; s_tready is high while the
//  queue holds at most one token, so a byte that ends a pending token and
//  emits its own can hold off the next byte until the queue drains.
//  Reset (aresetn low, synchronous) returns the scanner to idle and empties
//  the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyword_tokenizer_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tuser,   // [0] end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [5:0] token_kind, [7:6] zero
    output logic       m_tlast
);

    typedef enum logic [3:0] {
        MODE_IDLE, MODE_SLASH, MODE_COMMENT, MODE_CSTAR, MODE_COLON,
        MODE_DOT, MODE_LESS, MODE_GREATER, MODE_NUMBER, MODE_WORD
    } mode_t;

    typedef struct packed {
        kwt_pkg::token_t kind;
        logic            last;
    } entry_t;

    localparam int unsigned Q_DEPTH = 3;
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam int unsigned Q_IDX_W = $clog2(Q_DEPTH);

    mode_t              mode_reg, mode_next;
    kwt_pkg::word_buf_t word_buf_reg;
    kwt_pkg::word_len_t word_len_reg, word_len_next;
    logic               too_long_reg, too_long_next;
    entry_t             q_reg [Q_DEPTH];
    entry_t             q_next [Q_DEPTH];
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    logic                      in_fire, out_fire;
    logic [kwt_pkg::CHAR_W-1:0] ch, ch_low;
    logic                      buf_wr;
    logic [kwt_pkg::IDX_W-1:0] buf_idx;
    kwt_pkg::token_t           word_kind;
    logic                      has_a, has_b;
    kwt_pkg::token_t           kind_a, kind_b;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= kwt_pkg::CH_ZERO) && (c <= kwt_pkg::CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= kwt_pkg::CH_LO_A) && (c <= kwt_pkg::CH_LO_Z)) ||
               ((c >= kwt_pkg::CH_UP_A) && (c <= kwt_pkg::CH_UP_Z));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == kwt_pkg::CH_SPACE) ||
               ((c >= kwt_pkg::CH_TAB) && (c <= kwt_pkg::CH_CR));
    endfunction

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign ch       = s_tdata;
    assign ch_low   = ((ch >= kwt_pkg::CH_UP_A) && (ch <= kwt_pkg::CH_UP_Z)) ?
                      ch + kwt_pkg::CASE_OFFSET : ch;

    kwt_classify u_classify (
        .word_buf      (word_buf_reg),
        .word_len      (word_len_reg),
        .word_too_long (too_long_reg),
        .word_kind     (word_kind)
    );

    // Scan one byte: pending token (a), then the byte's own token (b)
    always_comb begin
        logic begin_tok;
        begin_tok     = 1'b0;
        has_a         = 1'b0;
        kind_a        = kwt_pkg::TK_END;
        has_b         = 1'b0;
        kind_b        = kwt_pkg::TK_END;
        mode_next     = mode_reg;
        word_len_next = word_len_reg;
        too_long_next = too_long_reg;
        buf_wr        = 1'b0;
        buf_idx       = word_len_reg[kwt_pkg::IDX_W-1:0];

        if (s_tuser) begin
            // Flush the pending token, then end
            unique case (mode_reg)
                MODE_SLASH:   begin has_a = 1'b1; kind_a = kwt_pkg::TK_DIV;    end
                MODE_COLON:   begin has_a = 1'b1; kind_a = kwt_pkg::TK_COLON;  end
                MODE_DOT:     begin has_a = 1'b1; kind_a = kwt_pkg::TK_PERIOD; end
                MODE_LESS:    begin has_a = 1'b1; kind_a = kwt_pkg::TK_LT;     end
                MODE_GREATER: begin has_a = 1'b1; kind_a = kwt_pkg::TK_GT;     end
                MODE_NUMBER:  begin has_a = 1'b1; kind_a = kwt_pkg::TK_NUM;    end
                MODE_WORD:    begin has_a = 1'b1; kind_a = word_kind;          end
                default: begin
                end
            endcase
            has_b         = 1'b1;
            kind_b        = kwt_pkg::TK_END;
            mode_next     = MODE_IDLE;
            word_len_next = '0;
            too_long_next = 1'b0;
        end else begin
            unique case (mode_reg)
                MODE_SLASH: begin
                    if (ch == kwt_pkg::CH_STAR) begin
                        mode_next = MODE_COMMENT;
                    end else begin
                        has_a = 1'b1; kind_a = kwt_pkg::TK_DIV; begin_tok = 1'b1;
                    end
                end
                MODE_COMMENT: begin
                    if (ch == kwt_pkg::CH_STAR) mode_next = MODE_CSTAR;
                end
                MODE_CSTAR: begin
                    if (ch == kwt_pkg::CH_SLASH) begin
                        mode_next = MODE_IDLE;
                    end else if (ch != kwt_pkg::CH_STAR) begin
                        mode_next = MODE_COMMENT;
                    end
                end
                MODE_COLON: begin
                    if (ch == kwt_pkg::CH_EQUAL) begin
                        has_a = 1'b1; kind_a = kwt_pkg::TK_ASSIGN; mode_next = MODE_IDLE;
                    end else begin
                        has_a = 1'b1; kind_a = kwt_pkg::TK_COLON; begin_tok = 1'b1;
                    end
                end
                MODE_DOT: begin
                    if (ch == kwt_pkg::CH_DOT) begin
                        has_a = 1'b1; kind_a = kwt_pkg::TK_RANGE; mode_next = MODE_IDLE;
                    end else begin
                        has_a = 1'b1; kind_a = kwt_pkg::TK_PERIOD; begin_tok = 1'b1;
                    end
                end
                MODE_LESS: begin
                    if (ch == kwt_pkg::CH_EQUAL) begin
                        has_a = 1'b1; kind_a = kwt_pkg::TK_LE; mode_next = MODE_IDLE;
                    end else if (ch == kwt_pkg::CH_GREATER) begin
                        has_a = 1'b1; kind_a = kwt_pkg::TK_NE; mode_next = MODE_IDLE;
                    end else begin
                        has_a = 1'b1; kind_a = kwt_pkg::TK_LT; begin_tok = 1'b1;
                    end
                end
                MODE_GREATER: begin
                    if (ch == kwt_pkg::CH_EQUAL) begin
                        has_a = 1'b1; kind_a = kwt_pkg::TK_GE; mode_next = MODE_IDLE;
                    end else begin
                        has_a = 1'b1; kind_a = kwt_pkg::TK_GT; begin_tok = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (!is_digit(ch)) begin
                        has_a = 1'b1; kind_a = kwt_pkg::TK_NUM; begin_tok = 1'b1;
                    end
                end
                MODE_WORD: begin
                    if (is_alpha(ch) || is_digit(ch) || ch == kwt_pkg::CH_UNDER) begin
                        // Append, or mark the word as too long
                        if (word_len_reg < kwt_pkg::word_len_t'(kwt_pkg::MAX_KEYWORD_LEN)) begin
                            buf_wr        = 1'b1;
                            word_len_next = word_len_reg + kwt_pkg::word_len_t'(1);
                        end else begin
                            too_long_next = 1'b1;
                        end
                    end else begin
                        has_a = 1'b1; kind_a = word_kind; begin_tok = 1'b1;
                    end
                end
                default: begin
                    begin_tok = 1'b1;
                end
            endcase
        end

        // Start a new token at a boundary
        if (begin_tok) begin
            mode_next = MODE_IDLE;
            if (!is_space(ch)) begin
                case (ch)
                    kwt_pkg::CH_SLASH:   mode_next = MODE_SLASH;
                    kwt_pkg::CH_COLON:   mode_next = MODE_COLON;
                    kwt_pkg::CH_DOT:     mode_next = MODE_DOT;
                    kwt_pkg::CH_LESS:    mode_next = MODE_LESS;
                    kwt_pkg::CH_GREATER: mode_next = MODE_GREATER;
                    kwt_pkg::CH_SEMI:    begin has_b = 1'b1; kind_b = kwt_pkg::TK_SEMI;      end
                    kwt_pkg::CH_LPAR:    begin has_b = 1'b1; kind_b = kwt_pkg::TK_OPEN_PAR;  end
                    kwt_pkg::CH_RPAR:    begin has_b = 1'b1; kind_b = kwt_pkg::TK_CLOSE_PAR; end
                    kwt_pkg::CH_LBR:     begin has_b = 1'b1; kind_b = kwt_pkg::TK_OPEN_BR;   end
                    kwt_pkg::CH_RBR:     begin has_b = 1'b1; kind_b = kwt_pkg::TK_CLOSE_BR;  end
                    kwt_pkg::CH_COMMA:   begin has_b = 1'b1; kind_b = kwt_pkg::TK_COMMA;     end
                    kwt_pkg::CH_MINUS:   begin has_b = 1'b1; kind_b = kwt_pkg::TK_SUB;       end
                    kwt_pkg::CH_PLUS:    begin has_b = 1'b1; kind_b = kwt_pkg::TK_ADD;       end
                    kwt_pkg::CH_STAR:    begin has_b = 1'b1; kind_b = kwt_pkg::TK_MUL;       end
                    kwt_pkg::CH_PERCENT: begin has_b = 1'b1; kind_b = kwt_pkg::TK_MOD;       end
                    kwt_pkg::CH_EQUAL:   begin has_b = 1'b1; kind_b = kwt_pkg::TK_EQ;        end
                    default: begin
                        if (is_digit(ch)) begin
                            mode_next = MODE_NUMBER;
                        end else if (is_alpha(ch)) begin
                            mode_next     = MODE_WORD;
                            buf_wr        = 1'b1;
                            buf_idx       = '0;
                            word_len_next = kwt_pkg::word_len_t'(1);
                            too_long_next = 1'b0;
                        end else begin
                            has_b = 1'b1; kind_b = kwt_pkg::TK_ERR;
                        end
                    end
                endcase
            end
        end
    end

    // Pop the head, then push this byte's tokens behind what remains
    always_comb begin
        logic [Q_CNT_W-1:0] base;
        base = cnt_reg - Q_CNT_W'(out_fire);
        for (int i = 0; i < Q_DEPTH; i++) begin
            q_next[i] = q_reg[i];
        end
        if (out_fire) begin
            for (int i = 0; i < Q_DEPTH - 1; i++) begin
                q_next[i] = q_reg[i+1];
            end
        end
        cnt_next = base;
        if (in_fire) begin
            if (has_a) begin
                q_next[base[Q_IDX_W-1:0]] = '{kind: kind_a, last: !has_b};
                if (has_b) begin
                    q_next[base[Q_IDX_W-1:0] + Q_IDX_W'(1)] = '{kind: kind_b, last: 1'b1};
                end
            end else if (has_b) begin
                q_next[base[Q_IDX_W-1:0]] = '{kind: kind_b, last: 1'b1};
            end
            cnt_next = base + Q_CNT_W'(has_a) + Q_CNT_W'(has_b);
        end
    end

    // Hold scanner state and the result queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            word_len_reg <= '0;
            too_long_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            if (in_fire) begin
                mode_reg     <= mode_next;
                word_len_reg <= word_len_next;
                too_long_reg <= too_long_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Word letters and queue payload need no reset
    always_ff @(posedge aclk) begin
        if (in_fire && buf_wr) begin
            word_buf_reg[buf_idx] <= ch_low;
        end
        for (int i = 0; i < Q_DEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    assign s_tready = (cnt_reg <= Q_CNT_W'(1));
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {{(8 - kwt_pkg::TOKEN_W){1'b0}}, q_reg[0].kind};
    assign m_tlast  = q_reg[0].last;

endmodule
